[hw/rtl/whp_pkg.sv]
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types and constants of the RIFF/WAVE PCM header parser: result kinds,
// error codes, chunk tags and the result record passed to the output register.
// ----------------------------------------------------------------------------
package whp_pkg;

	// Result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [3:0] ERR_RIFF_TAG   = 4'd0;
	localparam logic [3:0] ERR_WAVE_TAG   = 4'd1;
	localparam logic [3:0] ERR_NOT_PCM    = 4'd2;
	localparam logic [3:0] ERR_CHANNELS   = 4'd3;
	localparam logic [3:0] ERR_BITS       = 4'd4;
	localparam logic [3:0] ERR_ZERO_RATE  = 4'd5;
	localparam logic [3:0] ERR_ALIGN      = 4'd6;
	localparam logic [3:0] ERR_BYTE_RATE  = 4'd7;
	localparam logic [3:0] ERR_SIZE_BIG   = 4'd8;
	localparam logic [3:0] ERR_SIZE_ALIGN = 4'd9;
	localparam logic [3:0] ERR_MISSING    = 4'd10;

	// Tags, first stream byte in the most significant position
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FORMAT_PCM     = 32'h0000_0001;
	localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        last_data;
		logic [3:0]  error_code;
		logic [1:0]  channels;
		logic [4:0]  bits_per_sample;
		logic [31:0] sample_rate;
		logic [31:0] data_size;
	} whp_result_t;

endpackage

[hw/rtl/whp_parser.sv]
// ----------------------------------------------------------------------------
// whp_parser
// Input register and header parse state machine. Each registered byte updates
// the parse state, once the result register is free, and may produce one result record.
// ----------------------------------------------------------------------------
module whp_parser
	import whp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	input  logic        out_free,
	output whp_result_t res,
	output logic        res_load
);

	typedef enum logic [3:0] {
		PH_RIFF_TAG,
		PH_RIFF_SIZE,
		PH_WAVE_TAG,
		PH_FMT_HDR,
		PH_FMT_SKIP,
		PH_FMT_BODY,
		PH_FMT_EXTRA,
		PH_DATA_HDR,
		PH_DATA_SKIP,
		PH_DATA,
		PH_DONE,
		PH_HALT
	} phase_t;

	function automatic logic [31:0] set_lane(input logic [31:0] w, input logic [1:0] lane,
			input logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[8*lane +: 8] = b;
		return r;
	endfunction

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        advance;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] chunk_q, chunk_d;
	logic [31:0] riff_left_q, riff_left_d;
	logic [15:0] ch_q, ch_d;
	logic [31:0] rate_q, rate_d;
	logic [31:0] byte_rate_q, byte_rate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] data_left_q, data_left_d;
	logic [31:0] prod_q, prod_d;
	logic        pad_q, pad_d;

	whp_result_t res_c;
	logic        res_valid_c;
	logic        fail_c;
	logic [3:0]  fail_code;
	logic [15:0] bits_full;
	logic [18:0] align8;
	logic [18:0] ch_bits;
	logic [47:0] prod_full;
	logic        misaligned;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign res      = res_c;
	assign res_load = advance && res_valid_c;

	assign bits_full = {byte_s1, bits_q[7:0]};
	assign align8    = {align_q, 3'b000};
	// Channels and bits are already checked as 1 or 2 and 8 or 16 when this is used.
	assign ch_bits   = (ch_q == 16'd2) ? {2'b00, bits_full, 1'b0} : {3'b000, bits_full};
	assign prod_full = align_q * rate_q;

	always_comb begin
		phase_d     = phase_q;
		idx_d       = idx_q;
		tag_d       = tag_q;
		chunk_d     = chunk_q;
		riff_left_d = riff_left_q;
		ch_d        = ch_q;
		rate_d      = rate_q;
		byte_rate_d = byte_rate_q;
		align_d     = align_q;
		bits_d      = bits_q;
		data_left_d = data_left_q;
		prod_d      = prod_q;
		pad_d       = pad_q;
		res_c       = '0;
		res_valid_c = 1'b0;
		fail_c      = 1'b0;
		fail_code   = ERR_RIFF_TAG;
		misaligned  = 1'b0;

		if (phase_q == PH_DONE || phase_q == PH_HALT) begin
			// Nothing more is parsed after the data chunk or an error.
		end else if (end_s1) begin
			fail_c = 1'b1;
			if (phase_q == PH_RIFF_TAG || phase_q == PH_RIFF_SIZE) begin
				fail_code = ERR_RIFF_TAG;
			end else if (phase_q == PH_WAVE_TAG) begin
				fail_code = ERR_WAVE_TAG;
			end else begin
				fail_code = ERR_MISSING;
			end
		end else begin
			if (phase_q != PH_RIFF_TAG && phase_q != PH_RIFF_SIZE) begin
				riff_left_d = riff_left_q - 32'd1;
			end
			idx_d = idx_q + 4'd1;

			unique case (phase_q) inside
				PH_RIFF_TAG, PH_WAVE_TAG: begin
					tag_d = {tag_q[23:0], byte_s1};
					if (idx_q == 4'd3) begin
						idx_d = '0;
						if (phase_q == PH_RIFF_TAG) begin
							if (tag_d != TAG_RIFF) begin
								fail_c    = 1'b1;
								fail_code = ERR_RIFF_TAG;
							end else begin
								phase_d = PH_RIFF_SIZE;
							end
						end else begin
							if (tag_d != TAG_WAVE) begin
								fail_c    = 1'b1;
								fail_code = ERR_WAVE_TAG;
							end else begin
								phase_d = PH_FMT_HDR;
							end
						end
					end
				end
				PH_RIFF_SIZE: begin
					riff_left_d = set_lane((idx_q == 4'd0) ? 32'd0 : riff_left_q,
						idx_q[1:0], byte_s1);
					if (idx_q == 4'd3) begin
						phase_d = PH_WAVE_TAG;
						idx_d   = '0;
					end
				end
				PH_FMT_HDR, PH_DATA_HDR: begin
					if (idx_q < 4'd4) begin
						tag_d = {tag_q[23:0], byte_s1};
					end else begin
						chunk_d = set_lane((idx_q == 4'd4) ? 32'd0 : chunk_q,
							idx_q[1:0], byte_s1);
						if (idx_q == 4'd7) begin
							idx_d = '0;
							if (phase_q == PH_FMT_HDR) begin
								if (tag_q == TAG_FMT) begin
									phase_d = PH_FMT_BODY;
									tag_d   = '0;
								end else begin
									pad_d   = chunk_d[0];
									phase_d = (chunk_d == 32'd0) ? PH_FMT_HDR : PH_FMT_SKIP;
								end
							end else if (tag_q != TAG_DATA) begin
								pad_d   = chunk_d[0];
								phase_d = (chunk_d == 32'd0) ? PH_DATA_HDR : PH_DATA_SKIP;
							end else begin
								// Block align is 1, 2 or 4 once the format has passed.
								misaligned = (align_q[2] && (chunk_d[1:0] != 2'b00)) ||
									(align_q[1] && chunk_d[0]);
								if (riff_left_d < chunk_d) begin
									fail_c    = 1'b1;
									fail_code = ERR_SIZE_BIG;
								end else if (align_q == 16'd0 || misaligned) begin
									fail_c    = 1'b1;
									fail_code = ERR_SIZE_ALIGN;
								end else begin
									data_left_d           = chunk_d;
									phase_d               = (chunk_d == 32'd0) ? PH_DONE : PH_DATA;
									res_valid_c           = 1'b1;
									res_c.kind            = KIND_FORMAT;
									res_c.channels        = ch_q[1:0];
									res_c.bits_per_sample = bits_q[4:0];
									res_c.sample_rate     = rate_q;
									res_c.data_size       = chunk_d;
								end
							end
						end
					end
				end
				PH_FMT_SKIP, PH_DATA_SKIP, PH_FMT_EXTRA: begin
					if (chunk_q != 32'd0) begin
						chunk_d = chunk_q - 32'd1;
					end else begin
						pad_d = 1'b0;
					end
					if (chunk_d == 32'd0 && !pad_d) begin
						idx_d   = '0;
						phase_d = (phase_q == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
					end
				end
				PH_FMT_BODY: begin
					case (idx_q) inside
						4'd0:             tag_d = {24'd0, byte_s1};
						4'd1:             tag_d[15:8] = byte_s1;
						4'd2:             ch_d = {8'd0, byte_s1};
						4'd3:             ch_d[15:8] = byte_s1;
						4'd4:             rate_d = {24'd0, byte_s1};
						4'd5, 4'd6, 4'd7: rate_d = set_lane(rate_q, idx_q[1:0], byte_s1);
						4'd8:             byte_rate_d = {24'd0, byte_s1};
						4'd9, 4'd10, 4'd11: begin
							byte_rate_d = set_lane(byte_rate_q, idx_q[1:0], byte_s1);
						end
						4'd12:            align_d = {8'd0, byte_s1};
						4'd13: begin
							align_d[15:8] = byte_s1;
							if (tag_q != FORMAT_PCM) begin
								fail_c    = 1'b1;
								fail_code = ERR_NOT_PCM;
							end
						end
						4'd14: begin
							bits_d = {8'd0, byte_s1};
							// Align and rate are complete here; the product is checked next byte.
							prod_d = prod_full[31:0];
						end
						default: begin
							bits_d = bits_full;
							if (ch_q != 16'd1 && ch_q != 16'd2) begin
								fail_c    = 1'b1;
								fail_code = ERR_CHANNELS;
							end else if (bits_full != 16'd8 && bits_full != 16'd16) begin
								fail_c    = 1'b1;
								fail_code = ERR_BITS;
							end else if (rate_q == 32'd0) begin
								fail_c    = 1'b1;
								fail_code = ERR_ZERO_RATE;
							end else if (align8 != ch_bits) begin
								fail_c    = 1'b1;
								fail_code = ERR_ALIGN;
							end else if (byte_rate_q != prod_q) begin
								fail_c    = 1'b1;
								fail_code = ERR_BYTE_RATE;
							end else begin
								idx_d = '0;
								if (chunk_q > FMT_BODY_BYTES) begin
									pad_d   = chunk_q[0];
									chunk_d = chunk_q - FMT_BODY_BYTES;
									phase_d = PH_FMT_EXTRA;
								end else begin
									pad_d   = 1'b0;
									chunk_d = '0;
									phase_d = PH_DATA_HDR;
								end
							end
						end
					endcase
				end
				PH_DATA: begin
					data_left_d     = data_left_q - 32'd1;
					res_valid_c     = 1'b1;
					res_c.kind      = KIND_DATA;
					res_c.data_byte = byte_s1;
					res_c.last_data = (data_left_d == 32'd0);
					if (data_left_d == 32'd0) begin
						phase_d = PH_DONE;
						idx_d   = '0;
					end
				end
				default: begin
				end
			endcase
		end

		if (fail_c) begin
			phase_d          = PH_HALT;
			res_c            = '0;
			res_c.kind       = KIND_ERROR;
			res_c.error_code = fail_code;
			res_valid_c      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_RIFF_TAG;
			idx_q       <= '0;
			tag_q       <= '0;
			chunk_q     <= '0;
			riff_left_q <= '0;
			ch_q        <= '0;
			rate_q      <= '0;
			byte_rate_q <= '0;
			align_q     <= '0;
			bits_q      <= '0;
			data_left_q <= '0;
			prod_q      <= '0;
			pad_q       <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				tag_q       <= tag_d;
				chunk_q     <= chunk_d;
				riff_left_q <= riff_left_d;
				ch_q        <= ch_d;
				rate_q      <= rate_d;
				byte_rate_q <= byte_rate_d;
				align_q     <= align_d;
				bits_q      <= bits_d;
				data_left_q <= data_left_d;
				prod_q      <= prod_d;
				pad_q       <= pad_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= stream_end;
		end
	end

endmodule

[hw/rtl/whp_out_reg.sv]
// ----------------------------------------------------------------------------
// whp_out_reg
// Result register with valid/ready. It takes a new record whenever it is empty
// or its current record is transferred in the same cycle.
// ----------------------------------------------------------------------------
module whp_out_reg
	import whp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  whp_result_t res,
	input  logic        res_load,
	output logic        out_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        last_data,
	output logic [3:0]  error_code,
	output logic [1:0]  channels,
	output logic [4:0]  bits_per_sample,
	output logic [31:0] sample_rate,
	output logic [31:0] data_size
);

	logic        valid_q;
	whp_result_t res_q;

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid       = valid_q;
	assign kind            = res_q.kind;
	assign data_byte       = res_q.data_byte;
	assign last_data       = res_q.last_data;
	assign error_code      = res_q.error_code;
	assign channels        = res_q.channels;
	assign bits_per_sample = res_q.bits_per_sample;
	assign sample_rate     = res_q.sample_rate;
	assign data_size       = res_q.data_size;

endmodule

[hw/rtl/wave_header_parser_core.sv]
// ----------------------------------------------------------------------------
// wave_header_parser_core
// Streaming RIFF/WAVE PCM header parser. Checks the RIFF and WAVE tags, reads
// and validates the fmt chunk, checks the data chunk size, emits one format
// record and then passes the data bytes through with the last one flagged.
// The first error emits one error record and halts the block until reset.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_ready  | in_byte, stream_end
//   output  | out_valid / out_ready| kind, data_byte, last_data, error_code,
//           |                      | channels, bits_per_sample, sample_rate,
//           |                      | data_size
//
// One byte per cycle is taken unless the output stalls; each byte is parsed
// from the input register, and its record, if any, is output the cycle after.
// The parse state and the result register advance together, so a stalled
// output holds the input register and drops in_ready in the same cycle.
// Reset returns the parser to the RIFF tag search with all fields cleared.
// ----------------------------------------------------------------------------
module wave_header_parser_core
	import whp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        last_data,
	output logic [3:0]  error_code,
	output logic [1:0]  channels,
	output logic [4:0]  bits_per_sample,
	output logic [31:0] sample_rate,
	output logic [31:0] data_size
);

	whp_result_t res;
	logic        res_load;
	logic        out_free;

	whp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.out_free   (out_free),
		.res        (res),
		.res_load   (res_load)
	);

	whp_out_reg u_out_reg (
		.clk             (clk),
		.arst_n          (arst_n),
		.res             (res),
		.res_load        (res_load),
		.out_free        (out_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.data_byte       (data_byte),
		.last_data       (last_data),
		.error_code      (error_code),
		.channels        (channels),
		.bits_per_sample (bits_per_sample),
		.sample_rate     (sample_rate),
		.data_size       (data_size)
	);

endmodule

[tb/wave_header_parser_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_header_parser_core_test
// Feeds the parser one RIFF/WAVE stream byte by byte. A fixed lead-in covers
// the tags, the largest RIFF length and an odd skipped chunk. A randomized
// file follows: skipped chunks, short or long fmt chunks, a data chunk and an
// ending that is either clean or broken in one of several ways. Every record
// is checked against a byte-level model of the parser. The sender and the
// receiver idle at random in several phases.
// ----------------------------------------------------------------------------
module wave_header_parser_core_test;
	import whp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 100;
	localparam int FILE_ITEMS   = 380;

	typedef enum logic [3:0] {
		PH_RIFF_TAG, PH_RIFF_LEN, PH_WAVE_TAG, PH_FMT_HDR, PH_FMT_SKIP, PH_FMT_BODY,
		PH_FMT_EXTRA, PH_DATA_HDR, PH_DATA_SKIP, PH_DATA, PH_DONE, PH_HALT
	} parse_phase_e;

	typedef enum int {LULL_NONE, LULL_SENDER, LULL_RECEIVER, LULL_BOTH} lull_e;

	typedef enum int {
		END_CLEAN, END_EMPTY, END_CUT_DATA, END_CUT_SEARCH, END_BAD_FMT,
		END_SIZE_ALIGN, END_SIZE_BIG
	} file_end_e;

	typedef struct packed {
		logic       eos;
		logic [7:0] value;
	} stream_item_t;

	typedef struct packed {
		logic       silent;
		logic       eos;
		logic [7:0] value;
	} lead_row_t;

	// Lead-in up to the fmt search. No row of it may produce a record.
	localparam lead_row_t LEAD_IN [22] = '{
		'{1'b1, 1'b0, 8'h52}, '{1'b1, 1'b0, 8'h49}, '{1'b1, 1'b0, 8'h46}, '{1'b1, 1'b0, 8'h46},
		'{1'b1, 1'b0, 8'hFF}, '{1'b1, 1'b0, 8'hFF}, '{1'b1, 1'b0, 8'hFF}, '{1'b1, 1'b0, 8'hFF},
		'{1'b1, 1'b0, 8'h57}, '{1'b1, 1'b0, 8'h41}, '{1'b1, 1'b0, 8'h56}, '{1'b1, 1'b0, 8'h45},
		'{1'b1, 1'b0, 8'h4A}, '{1'b1, 1'b0, 8'h55}, '{1'b1, 1'b0, 8'h4E}, '{1'b1, 1'b0, 8'h4B},
		'{1'b1, 1'b0, 8'h01}, '{1'b1, 1'b0, 8'h00}, '{1'b1, 1'b0, 8'h00}, '{1'b1, 1'b0, 8'h00},
		'{1'b1, 1'b0, 8'hFF}, '{1'b1, 1'b0, 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        last_data;
	logic [3:0]  error_code;
	logic [1:0]  channels;
	logic [4:0]  bits_per_sample;
	logic [31:0] sample_rate;
	logic [31:0] data_size;

	// Parser model state
	parse_phase_e ph = PH_RIFF_TAG;
	logic [31:0]  ph_idx = '0;
	logic [31:0]  tag_acc = '0;
	logic [31:0]  chunk_left = '0;
	logic [31:0]  riff_left = '0;
	logic [15:0]  f_channels = '0;
	logic [31:0]  f_rate = '0;
	logic [31:0]  f_byte_rate = '0;
	logic [15:0]  f_align = '0;
	logic [15:0]  f_bits = '0;
	logic [31:0]  data_left = '0;
	logic [31:0]  data_len = '0;
	logic         pad_due = 1'b0;

	whp_result_t  pending_records[$];
	stream_item_t file_q[$];
	whp_result_t  want_rec;
	lull_e        lull = LULL_NONE;
	int           accepted_count = 0;
	int           fail_count = 0;
	int           cycle_count = 0;

	wave_header_parser_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_byte         (in_byte),
		.stream_end      (stream_end),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.data_byte       (data_byte),
		.last_data       (last_data),
		.error_code      (error_code),
		.channels        (channels),
		.bits_per_sample (bits_per_sample),
		.sample_rate     (sample_rate),
		.data_size       (data_size)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >=
			((lull == LULL_RECEIVER) ? 60 : (lull == LULL_BOTH) ? 14 : 0));
	end

	// ------------------------------------------------------------------------
	// Byte-level parser model
	// ------------------------------------------------------------------------
	task automatic enter(input parse_phase_e p);
		ph = p;
		ph_idx = '0;
	endtask

	task automatic post_error(input logic [3:0] code);
		whp_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		ph = PH_HALT;
		pending_records.push_back(r);
	endtask

	// A skip ends once the count is spent and no pad byte is owed.
	task automatic skip_end(input parse_phase_e next);
		if (chunk_left == 0 && !pad_due)
			enter(next);
	endtask

	task automatic skip_one(input parse_phase_e next);
		if (chunk_left != 0)
			chunk_left = chunk_left - 1;
		else
			pad_due = 1'b0;
		skip_end(next);
	endtask

	task automatic track_byte(input stream_item_t item);
		logic [31:0] i;
		logic [31:0] b32;
		logic [4:0]  sh;
		logic [63:0] prod;
		whp_result_t r;
		i = ph_idx;
		b32 = {24'd0, item.value};
		sh = {i[1:0], 3'b000};
		r = '0;
		if (ph == PH_DONE || ph == PH_HALT)
			return;
		if (item.eos) begin
			if (ph == PH_RIFF_TAG || ph == PH_RIFF_LEN)
				post_error(ERR_RIFF_TAG);
			else if (ph == PH_WAVE_TAG)
				post_error(ERR_WAVE_TAG);
			else
				post_error(ERR_MISSING);
			return;
		end
		if (ph >= PH_WAVE_TAG)
			riff_left = riff_left - 1;
		ph_idx = i + 1;
		case (ph)
			PH_RIFF_TAG, PH_WAVE_TAG: begin
				tag_acc = {tag_acc[23:0], item.value};
				if (i == 3) begin
					if (ph == PH_RIFF_TAG) begin
						if (tag_acc != TAG_RIFF)
							post_error(ERR_RIFF_TAG);
						else
							enter(PH_RIFF_LEN);
					end else if (tag_acc != TAG_WAVE) begin
						post_error(ERR_WAVE_TAG);
					end else begin
						enter(PH_FMT_HDR);
					end
				end
			end
			PH_RIFF_LEN: begin
				if (i == 0)
					riff_left = '0;
				riff_left = riff_left | (b32 << sh);
				if (i == 3)
					enter(PH_WAVE_TAG);
			end
			PH_FMT_HDR, PH_DATA_HDR: begin
				if (i < 4) begin
					tag_acc = {tag_acc[23:0], item.value};
				end else begin
					if (i == 4)
						chunk_left = '0;
					chunk_left = chunk_left | (b32 << sh);
					if (i == 7) begin
						if (ph == PH_FMT_HDR) begin
							if (tag_acc == TAG_FMT) begin
								enter(PH_FMT_BODY);
								tag_acc = '0;
							end else begin
								pad_due = chunk_left[0];
								enter(PH_FMT_SKIP);
								skip_end(PH_FMT_HDR);
							end
						end else if (tag_acc != TAG_DATA) begin
							pad_due = chunk_left[0];
							enter(PH_DATA_SKIP);
							skip_end(PH_DATA_HDR);
						end else begin
							data_len = chunk_left;
							if (riff_left < data_len) begin
								post_error(ERR_SIZE_BIG);
							end else if (f_align == 0 || (data_len % f_align) != 0) begin
								post_error(ERR_SIZE_ALIGN);
							end else begin
								data_left = data_len;
								if (data_len == 0)
									enter(PH_DONE);
								else
									enter(PH_DATA);
								r.kind = KIND_FORMAT;
								r.channels = f_channels[1:0];
								r.bits_per_sample = f_bits[4:0];
								r.sample_rate = f_rate;
								r.data_size = data_len;
								pending_records.push_back(r);
							end
						end
					end
				end
			end
			PH_FMT_SKIP: skip_one(PH_FMT_HDR);
			PH_DATA_SKIP, PH_FMT_EXTRA: skip_one(PH_DATA_HDR);
			PH_FMT_BODY: begin
				if (i < 2) begin
					tag_acc = (i == 0) ? b32 : (tag_acc | (b32 << 8));
				end else if (i < 4) begin
					f_channels = (i == 2) ? {8'd0, item.value} : {item.value, f_channels[7:0]};
				end else if (i < 8) begin
					f_rate = (i == 4) ? b32 : (f_rate | (b32 << sh));
				end else if (i < 12) begin
					f_byte_rate = (i == 8) ? b32 : (f_byte_rate | (b32 << sh));
				end else if (i < 14) begin
					f_align = (i == 12) ? {8'd0, item.value} : {item.value, f_align[7:0]};
					if (i == 13 && tag_acc != FORMAT_PCM)
						post_error(ERR_NOT_PCM);
				end else begin
					f_bits = (i == 14) ? {8'd0, item.value} : {item.value, f_bits[7:0]};
					if (i == 15) begin
						prod = {48'd0, f_align} * {32'd0, f_rate};
						if (f_channels != 1 && f_channels != 2) begin
							post_error(ERR_CHANNELS);
						end else if (f_bits != 8 && f_bits != 16) begin
							post_error(ERR_BITS);
						end else if (f_rate == 0) begin
							post_error(ERR_ZERO_RATE);
						end else if ({13'd0, f_align, 3'd0} !=
								{16'd0, f_channels} * {16'd0, f_bits}) begin
							post_error(ERR_ALIGN);
						end else if (f_byte_rate != prod[31:0]) begin
							post_error(ERR_BYTE_RATE);
						end else begin
							// Only bytes past the 16 body bytes remain to skip.
							if (chunk_left > FMT_BODY_BYTES) begin
								pad_due = chunk_left[0];
								chunk_left = chunk_left - FMT_BODY_BYTES;
							end else begin
								pad_due = 1'b0;
								chunk_left = '0;
							end
							enter(PH_FMT_EXTRA);
							skip_end(PH_DATA_HDR);
						end
					end
				end
			end
			PH_DATA: begin
				data_left = data_left - 1;
				if (data_left == 0)
					enter(PH_DONE);
				r.kind = KIND_DATA;
				r.data_byte = item.value;
				r.last_data = (data_left == 0);
				pending_records.push_back(r);
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------------
	task automatic put_byte(input logic [7:0] b, input logic eos);
		stream_item_t it;
		it.eos = eos;
		it.value = b;
		file_q.push_back(it);
	endtask

	task automatic put_le(input logic [31:0] w, input int n);
		for (int k = 0; k < n; k++)
			put_byte(w[8*k +: 8], 1'b0);
	endtask

	task automatic put_tag(input logic [31:0] t);
		for (int k = 3; k >= 0; k--)
			put_byte(t[8*k +: 8], 1'b0);
	endtask

	task automatic put_random(input int n);
		for (int k = 0; k < n; k++)
			put_byte(8'($urandom), 1'b0);
	endtask

	// Odd-sized chunks carry one pad byte after the body.
	task automatic put_skipped_chunk(input logic [31:0] t, input int len);
		put_tag(t);
		put_le(len, 4);
		put_random(len + (len % 2));
	endtask

	function automatic logic [31:0] stray_tag();
		logic [31:0] t;
		t = $urandom;
		if (t == TAG_FMT || t == TAG_DATA)
			t = ~t;
		return t;
	endfunction

	task automatic build_file();
		file_end_e   ending;
		int          r;
		int          ch;
		int          bits;
		int          good_align;
		int          fmt_len;
		int          n;
		logic [3:0]  broken;
		logic [15:0] fmt_code;
		logic [15:0] ch_f;
		logic [15:0] bits_f;
		logic [15:0] align_f;
		logic [31:0] rate;
		logic [31:0] brate;
		logic [31:0] dsize;
		r = $urandom_range(0, 15);
		ending = (r < 10) ? END_CLEAN : file_end_e'(r - 9);

		// A chunk tagged data ahead of fmt is skipped like any other.
		repeat ($urandom_range(0, 2))
			put_skipped_chunk(($urandom_range(0, 2) == 0) ? TAG_DATA : stray_tag(),
				$urandom_range(0, 7));

		ch = (ending == END_SIZE_ALIGN) ? 2 : $urandom_range(1, 2);
		bits = $urandom_range(0, 1) ? 16 : 8;
		good_align = ch * bits / 8;
		fmt_code = FORMAT_PCM[15:0];
		ch_f = 16'(ch);
		bits_f = 16'(bits);
		align_f = 16'(good_align);
		case ($urandom_range(0, 4))
			0: rate = 32'd1;
			1: rate = '1;
			2: rate = 32'd44100;
			default: rate = $urandom | 32'd1;
		endcase
		brate = {16'd0, align_f} * rate;
		if (ending == END_BAD_FMT) begin
			broken = 4'($urandom_range(ERR_NOT_PCM, ERR_BYTE_RATE));
			case (broken)
				ERR_NOT_PCM: begin
					fmt_code = 16'($urandom);
					if (fmt_code == FORMAT_PCM[15:0])
						fmt_code = '0;
				end
				ERR_CHANNELS: begin
					ch_f = $urandom_range(0, 1) ? 16'd3 : 16'($urandom);
					if (ch_f == 1 || ch_f == 2)
						ch_f = '0;
				end
				ERR_BITS: begin
					bits_f = $urandom_range(0, 1) ? 16'd24 : 16'($urandom);
					if (bits_f == 8 || bits_f == 16)
						bits_f = '0;
				end
				ERR_ZERO_RATE: begin
					rate = '0;
					brate = '0;
				end
				ERR_ALIGN: align_f = align_f + 16'd1;
				default: brate = brate + 32'd1;
			endcase
		end

		case ($urandom_range(0, 6))
			0: fmt_len = 14;
			1: fmt_len = 15;
			2, 3: fmt_len = 16;
			4: fmt_len = 17;
			5: fmt_len = 18;
			default: fmt_len = 21;
		endcase
		put_tag(TAG_FMT);
		put_le(fmt_len, 4);
		put_le({16'd0, fmt_code}, 2);
		put_le({16'd0, ch_f}, 2);
		put_le(rate, 4);
		put_le(brate, 4);
		put_le({16'd0, align_f}, 2);
		put_le({16'd0, bits_f}, 2);
		if (fmt_len > 16)
			put_random(fmt_len - 16 + (fmt_len % 2));

		repeat ($urandom_range(0, 2))
			put_skipped_chunk(($urandom_range(0, 2) == 0) ? TAG_FMT : stray_tag(),
				$urandom_range(0, 7));

		if (ending == END_CUT_SEARCH) begin
			put_random($urandom_range(0, 6));
			put_byte(8'($urandom), 1'b1);
		end else begin
			n = $urandom_range(300, 500);
			dsize = n - (n % good_align);
			if (ending == END_EMPTY)
				dsize = '0;
			else if (ending == END_SIZE_ALIGN)
				dsize = dsize + 32'd1;
			else if (ending == END_SIZE_BIG)
				dsize = '1;
			put_tag(TAG_DATA);
			put_le(dsize, 4);
			if (ending == END_CLEAN) begin
				put_random(dsize);
			end else if (ending == END_CUT_DATA) begin
				put_random(dsize / 2);
				put_byte(8'($urandom), 1'b1);
			end else begin
				put_random(4);
			end
		end

		// Trailing bytes and a stream end land after the block stopped parsing.
		put_random(3);
		put_byte(8'($urandom), 1'b1);
		put_random(1);
		// Short files are topped up so every idling phase still sees traffic.
		while (file_q.size() < FILE_ITEMS)
			put_random(1);
	endtask

	// ------------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------------
	task automatic send_item(input stream_item_t item, input logic silent);
		int held;
		while ($urandom_range(99) <
				((lull == LULL_SENDER) ? 60 : (lull == LULL_BOTH) ? 14 : 0)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= item.value;
		stream_end <= item.eos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		held = pending_records.size();
		track_byte(item);
		// A silent row expects no record whatever the model says.
		if (silent) begin
			while (pending_records.size() > held)
				void'(pending_records.pop_back());
		end
		accepted_count++;
		lull = lull_e'((accepted_count / PHASE_ITEMS) % 4);
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_records.size() == 0) begin
				$display("%0t: record transfer with none expected, actual kind %0d code %0d",
					$time, kind, error_code);
				fail_count++;
			end else begin
				want_rec = pending_records.pop_front();
				check_field("kind", {30'd0, want_rec.kind}, {30'd0, kind});
				check_field("data_byte", {24'd0, want_rec.data_byte}, {24'd0, data_byte});
				check_field("last_data", {31'd0, want_rec.last_data}, {31'd0, last_data});
				check_field("error_code", {28'd0, want_rec.error_code}, {28'd0, error_code});
				check_field("channels", {30'd0, want_rec.channels}, {30'd0, channels});
				check_field("bits_per_sample", {27'd0, want_rec.bits_per_sample},
					{27'd0, bits_per_sample});
				check_field("sample_rate", want_rec.sample_rate, sample_rate);
				check_field("data_size", want_rec.data_size, data_size);
			end
		end
	end

	initial begin
		stream_item_t it;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		foreach (LEAD_IN[k]) begin
			it.eos = LEAD_IN[k].eos;
			it.value = LEAD_IN[k].value;
			send_item(it, LEAD_IN[k].silent);
		end
		build_file();
		while (file_q.size() > 0)
			send_item(file_q.pop_front(), 1'b0);
		in_valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
